### hw/rtl/gibt_pkg.sv
// ----------------------------------------------------------------------------
// gibt_pkg
// Shared types and constants of the greedy IoU box tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package gibt_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int RES_CW      = 5;
    localparam int DW          = 20;
    localparam int MW          = 2 * DW;
    localparam int PW          = 2 * MW;

    localparam logic [31:0] KEEP_MIN_MS   = 32'd4000;
    localparam logic [31:0] SHOW_MS       = 32'd1000;
    localparam logic [31:0] COAST_MS      = 32'd200;
    localparam logic [7:0]  MIN_SIGHTINGS = 8'd3;
    localparam logic [7:0]  MAX_SIGHTINGS = 8'd255;
    localparam logic [13:0] WINDOW_MIN    = 14'd1000;
    localparam logic [13:0] WINDOW_MAX    = 14'd10000;
    localparam logic [13:0] WINDOW_RESET  = 14'd3000;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
    } box_t;

    typedef struct packed {
        logic [31:0] ident;
        box_t        box;
        logic [15:0] score;
        logic [31:0] seen;
        logic [7:0]  sight;
    } slot_t;

    typedef struct packed {
        logic          start;
        logic [MW-1:0] a;
        logic [MW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [PW-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic [31:0] track_number;
        box_t        box;
        logic [15:0] score;
        logic        coasting;
        logic        nothing_shown;
        logic        table_full;
        logic        last;
    } res_t;

endpackage

`default_nettype wire

### hw/rtl/gibt_if.sv
// ----------------------------------------------------------------------------
// gibt_if
// Valid/ready channels of the tracker: input items, results, configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface gibt_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] frame_time_ms;
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_width;
    logic [15:0] box_height;
    logic [15:0] det_score;

    modport source (output valid, kind, frame_time_ms, box_left, box_top, box_width,
                    box_height, det_score, input ready);
    modport sink   (input valid, kind, frame_time_ms, box_left, box_top, box_width,
                    box_height, det_score, output ready);
endinterface

interface gibt_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] track_number;
    logic [15:0] out_left;
    logic [15:0] out_top;
    logic [15:0] out_width;
    logic [15:0] out_height;
    logic [15:0] out_score;
    logic        coasting;
    logic        nothing_shown;
    logic        table_full;
    logic        last;

    modport source (output valid, track_number, out_left, out_top, out_width, out_height,
                    out_score, coasting, nothing_shown, table_full, last, input ready);
    modport sink   (input valid, track_number, out_left, out_top, out_width, out_height,
                    out_score, coasting, nothing_shown, table_full, last, output ready);
endinterface

interface gibt_cfg_if;
    logic        valid;
    logic        ready;
    logic [13:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/gibt_mul.sv
// ----------------------------------------------------------------------------
// gibt_mul
// Shared multiplier: one digit by one digit partial product per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module gibt_mul import gibt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [MW-1:0] a_reg;
    logic [MW-1:0] b_reg;
    logic [PW-1:0] acc_reg;
    logic [DW-1:0] a_dig;
    logic [DW-1:0] b_dig;
    logic [MW-1:0] pp;
    logic [PW-1:0] pp_sh;

    always_comb
    begin
        a_dig = cnt_reg[1] ? a_reg[MW-1:DW] : a_reg[DW-1:0];
        b_dig = cnt_reg[0] ? b_reg[MW-1:DW] : b_reg[DW-1:0];
        pp    = a_dig * b_dig;
        case ({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]})
            2'd0:    pp_sh = PW'(pp);
            2'd1:    pp_sh = PW'(pp) << DW;
            default: pp_sh = PW'(pp) << (2 * DW);
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            a_reg   <= req.a;
            b_reg   <= req.b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_reg + pp_sh;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

`default_nettype wire

### hw/rtl/gibt_store.sv
// ----------------------------------------------------------------------------
// gibt_store
// Track slot memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gibt_store import gibt_pkg::*;
#(
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  slot_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output slot_t         rd_data
);

    slot_t slot_mem [DEPTH];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/greedy_iou_box_tracker_top.sv
// ----------------------------------------------------------------------------
// greedy_iou_box_tracker_top
// Greedy IoU / centroid box tracker with sequencer, shared multiplier, slots.
// ----------------------------------------------------------------------------
// detection: own area first, then an IoU pass over the slots with products for eligible slots;
//   if no IoU match is found, a centroid pass with products for eligible slots,
//   then the best track is updated or a free slot is opened for a new one
// frame end: expiry sweep, then a scan per emitted track and a final scan, plus result
//   stalls; input not ready while an item is in work
// reset: all slots free, id counter 0, window 3000 ms; no clearing pass needed
`default_nettype none

module greedy_iou_box_tracker_top import gibt_pkg::*;
#(
    parameter int MAX_TRACKS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    gibt_item_if.sink    item,
    gibt_res_if.source   result,
    gibt_cfg_if.sink     cfg
);

    localparam int IW = $clog2(MAX_TRACKS);
    localparam int CW = $clog2(MAX_TRACKS + 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DA    = 5'd1;
    localparam logic [4:0] S_DA_W  = 5'd2;
    localparam logic [4:0] S_I_RD  = 5'd3;
    localparam logic [4:0] S_I_GEO = 5'd4;
    localparam logic [4:0] S_I_M1  = 5'd5;
    localparam logic [4:0] S_I_M2  = 5'd6;
    localparam logic [4:0] S_I_DEC = 5'd7;
    localparam logic [4:0] S_I_M3  = 5'd8;
    localparam logic [4:0] S_I_M4  = 5'd9;
    localparam logic [4:0] S_C_RD  = 5'd10;
    localparam logic [4:0] S_C_GEO = 5'd11;
    localparam logic [4:0] S_C_M1  = 5'd12;
    localparam logic [4:0] S_C_M2  = 5'd13;
    localparam logic [4:0] S_C_M3  = 5'd14;
    localparam logic [4:0] S_C_DEC = 5'd15;
    localparam logic [4:0] S_C_M4  = 5'd16;
    localparam logic [4:0] S_C_M5  = 5'd17;
    localparam logic [4:0] S_U_RD  = 5'd18;
    localparam logic [4:0] S_U_WR  = 5'd19;
    localparam logic [4:0] S_NEW   = 5'd20;
    localparam logic [4:0] S_X_RD  = 5'd21;
    localparam logic [4:0] S_X_CHK = 5'd22;
    localparam logic [4:0] S_E_RD  = 5'd23;
    localparam logic [4:0] S_E_CHK = 5'd24;
    localparam logic [4:0] S_E_END = 5'd25;
    localparam logic [4:0] S_O_RD  = 5'd26;
    localparam logic [4:0] S_O_LD  = 5'd27;
    localparam logic [4:0] S_LASTP = 5'd28;
    localparam logic [4:0] S_FIN   = 5'd29;

    logic [4:0]            state_reg, state_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [IW-1:0]         best_reg, best_next;
    logic                  found_reg, found_next;
    logic [MAX_TRACKS-1:0] valid_reg, valid_next;
    logic [MAX_TRACKS-1:0] used_reg, used_next;
    logic [MAX_TRACKS-1:0] shown_reg, shown_next;
    logic [31:0]           next_id_reg, next_id_next;
    logic                  dropped_reg, dropped_next;
    logic [13:0]           window_reg, window_next;
    logic [RES_CW-1:0]     res_cnt_reg, res_cnt_next;
    logic                  pend_v_reg, pend_v_next;
    logic                  out_v_reg, out_v_next;

    logic [31:0]   t_reg, t_next;
    box_t          dbox_reg, dbox_next;
    logic [15:0]   dscore_reg, dscore_next;
    logic [31:0]   darea_reg, darea_next;
    logic [31:0]   inter_reg, inter_next;
    logic [33:0]   union_reg, union_next;
    logic [31:0]   bi_reg, bi_next;
    logic [33:0]   bu_reg, bu_next;
    logic [PW-1:0] p1_reg, p1_next;
    logic [17:0]   ay_reg, ay_next;
    logic [17:0]   s_reg, s_next;
    logic [36:0]   d2_reg, d2_next;
    logic [35:0]   s2_reg, s2_next;
    logic [36:0]   bd_reg, bd_next;
    logic [35:0]   bs2_reg, bs2_next;
    logic [31:0]   pick_id_reg, pick_id_next;
    res_t          pend_reg, pend_next;
    res_t          out_reg, out_next;

    mul_req_t      mreq;
    mul_rsp_t      mrsp;
    slot_t         rd;
    slot_t         wr_data;
    logic          wr_en;
    logic [IW-1:0] wr_addr;

    logic [IW-1:0] idx_i;
    logic          idx_end;
    logic          elig;
    logic [15:0]   x0, y0;
    logic [16:0]   ar, br, ab, bb, x1, y1;
    logic          empty;
    logic [16:0]   iw, ih;
    logic [17:0]   cx_d, cx_r, cy_d, cy_r, adx, ady, s_sum;
    logic [31:0]   elapsed;
    logic [31:0]   keep;
    logic          out_free;
    logic [35:0]   iou_lhs, iou_rhs;
    logic [41:0]   cen_lhs, cen_rhs;
    logic [13:0]   cfg_clamped;

    gibt_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    gibt_store #(.DEPTH(MAX_TRACKS)) u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_i),
        .rd_data (rd)
    );

    // geometry of the detection against the slot being read
    always_comb
    begin
        idx_i   = idx_reg[IW-1:0];
        idx_end = (idx_reg == CW'(MAX_TRACKS));
        elig    = valid_reg[idx_i] && !used_reg[idx_i];

        x0    = (dbox_reg.left > rd.box.left) ? dbox_reg.left : rd.box.left;
        y0    = (dbox_reg.top > rd.box.top) ? dbox_reg.top : rd.box.top;
        ar    = 17'(dbox_reg.left) + 17'(dbox_reg.width);
        br    = 17'(rd.box.left) + 17'(rd.box.width);
        ab    = 17'(dbox_reg.top) + 17'(dbox_reg.height);
        bb    = 17'(rd.box.top) + 17'(rd.box.height);
        x1    = (ar < br) ? ar : br;
        y1    = (ab < bb) ? ab : bb;
        empty = (x1 <= 17'(x0)) || (y1 <= 17'(y0));
        iw    = x1 - 17'(x0);
        ih    = y1 - 17'(y0);

        cx_d  = (18'(dbox_reg.left) << 1) + 18'(dbox_reg.width);
        cx_r  = (18'(rd.box.left) << 1) + 18'(rd.box.width);
        cy_d  = (18'(dbox_reg.top) << 1) + 18'(dbox_reg.height);
        cy_r  = (18'(rd.box.top) << 1) + 18'(rd.box.height);
        adx   = (cx_d >= cx_r) ? (cx_d - cx_r) : (cx_r - cx_d);
        ady   = (cy_d >= cy_r) ? (cy_d - cy_r) : (cy_r - cy_d);
        s_sum = 18'(dbox_reg.width) + 18'(rd.box.width)
              + 18'(dbox_reg.height) + 18'(rd.box.height);

        // 10*inter > 3*union and 25*d2 < 9*s2
        iou_lhs = (36'(inter_reg) << 3) + (36'(inter_reg) << 1);
        iou_rhs = (36'(union_reg) << 1) + 36'(union_reg);
        cen_lhs = (42'(d2_reg) << 4) + (42'(d2_reg) << 3) + 42'(d2_reg);
        cen_rhs = (42'(s2_reg) << 3) + 42'(s2_reg);

        elapsed  = t_reg - rd.seen;
        keep     = (32'(window_reg) > KEEP_MIN_MS) ? 32'(window_reg) : KEEP_MIN_MS;
        out_free = !out_v_reg || result.ready;

        if (cfg.data < WINDOW_MIN)
            cfg_clamped = WINDOW_MIN;
        else if (cfg.data > WINDOW_MAX)
            cfg_clamped = WINDOW_MAX;
        else
            cfg_clamped = cfg.data;
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        best_next    = best_reg;
        found_next   = found_reg;
        valid_next   = valid_reg;
        used_next    = used_reg;
        shown_next   = shown_reg;
        next_id_next = next_id_reg;
        dropped_next = dropped_reg;
        window_next  = window_reg;
        res_cnt_next = res_cnt_reg;
        pend_v_next  = pend_v_reg;
        out_v_next   = out_v_reg;
        t_next       = t_reg;
        dbox_next    = dbox_reg;
        dscore_next  = dscore_reg;
        darea_next   = darea_reg;
        inter_next   = inter_reg;
        union_next   = union_reg;
        bi_next      = bi_reg;
        bu_next      = bu_reg;
        p1_next      = p1_reg;
        ay_next      = ay_reg;
        s_next       = s_reg;
        d2_next      = d2_reg;
        s2_next      = s2_reg;
        bd_next      = bd_reg;
        bs2_next     = bs2_reg;
        pick_id_next = pick_id_reg;
        pend_next    = pend_reg;
        out_next     = out_reg;
        mreq         = '0;
        wr_en        = 1'b0;
        wr_addr      = best_reg;
        wr_data      = rd;

        if (cfg.valid)
            window_next = cfg_clamped;

        if (result.valid && result.ready)
            out_v_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    t_next      = item.frame_time_ms;
                    dbox_next   = '{item.box_left, item.box_top, item.box_width,
                                    item.box_height};
                    dscore_next = item.det_score;
                    idx_next    = '0;
                    state_next  = item.kind ? S_X_RD : S_DA;
                end
            end
            S_DA:
            begin
                mreq       = '{1'b1, MW'(dbox_reg.width), MW'(dbox_reg.height)};
                state_next = S_DA_W;
            end
            S_DA_W:
            begin
                if (mrsp.done)
                begin
                    darea_next = mrsp.prod[31:0];
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_I_RD;
                end
            end
            S_I_RD:
            begin
                if (idx_end)
                begin
                    if (found_reg)
                    begin
                        idx_next   = CW'(best_reg);
                        state_next = S_U_RD;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_C_RD;
                    end
                end
                else if (elig)
                    state_next = S_I_GEO;
                else
                    idx_next = idx_reg + CW'(1);
            end
            S_I_GEO:
            begin
                if (empty)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_I_RD;
                end
                else
                begin
                    mreq       = '{1'b1, MW'(iw), MW'(ih)};
                    state_next = S_I_M1;
                end
            end
            S_I_M1:
            begin
                if (mrsp.done)
                begin
                    inter_next = mrsp.prod[31:0];
                    mreq       = '{1'b1, MW'(rd.box.width), MW'(rd.box.height)};
                    state_next = S_I_M2;
                end
            end
            S_I_M2:
            begin
                if (mrsp.done)
                begin
                    union_next = 34'(darea_reg) + 34'(mrsp.prod[31:0]) - 34'(inter_reg);
                    state_next = S_I_DEC;
                end
            end
            S_I_DEC:
            begin
                if (!found_reg)
                begin
                    if (iou_lhs > iou_rhs)
                    begin
                        found_next = 1'b1;
                        best_next  = idx_i;
                        bi_next    = inter_reg;
                        bu_next    = union_reg;
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_I_RD;
                end
                else
                begin
                    mreq       = '{1'b1, MW'(bi_reg), MW'(union_reg)};
                    state_next = S_I_M3;
                end
            end
            S_I_M3:
            begin
                if (mrsp.done)
                begin
                    p1_next    = mrsp.prod;
                    mreq       = '{1'b1, MW'(inter_reg), MW'(bu_reg)};
                    state_next = S_I_M4;
                end
            end
            S_I_M4:
            begin
                if (mrsp.done)
                begin
                    if (p1_reg < mrsp.prod)
                    begin
                        best_next = idx_i;
                        bi_next   = inter_reg;
                        bu_next   = union_reg;
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_I_RD;
                end
            end
            S_C_RD:
            begin
                if (idx_end)
                begin
                    if (found_reg)
                    begin
                        idx_next   = CW'(best_reg);
                        state_next = S_U_RD;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_NEW;
                    end
                end
                else if (elig)
                    state_next = S_C_GEO;
                else
                    idx_next = idx_reg + CW'(1);
            end
            S_C_GEO:
            begin
                if (s_sum == '0)
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_C_RD;
                end
                else
                begin
                    ay_next    = ady;
                    s_next     = s_sum;
                    mreq       = '{1'b1, MW'(adx), MW'(adx)};
                    state_next = S_C_M1;
                end
            end
            S_C_M1:
            begin
                if (mrsp.done)
                begin
                    d2_next    = mrsp.prod[36:0];
                    mreq       = '{1'b1, MW'(ay_reg), MW'(ay_reg)};
                    state_next = S_C_M2;
                end
            end
            S_C_M2:
            begin
                if (mrsp.done)
                begin
                    d2_next    = d2_reg + mrsp.prod[36:0];
                    mreq       = '{1'b1, MW'(s_reg), MW'(s_reg)};
                    state_next = S_C_M3;
                end
            end
            S_C_M3:
            begin
                if (mrsp.done)
                begin
                    s2_next    = mrsp.prod[35:0];
                    state_next = S_C_DEC;
                end
            end
            S_C_DEC:
            begin
                if (!(cen_lhs < cen_rhs) || !found_reg)
                begin
                    if (cen_lhs < cen_rhs)
                    begin
                        found_next = 1'b1;
                        best_next  = idx_i;
                        bd_next    = d2_reg;
                        bs2_next   = s2_reg;
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_C_RD;
                end
                else
                begin
                    mreq       = '{1'b1, MW'(d2_reg), MW'(bs2_reg)};
                    state_next = S_C_M4;
                end
            end
            S_C_M4:
            begin
                if (mrsp.done)
                begin
                    p1_next    = mrsp.prod;
                    mreq       = '{1'b1, MW'(bd_reg), MW'(s2_reg)};
                    state_next = S_C_M5;
                end
            end
            S_C_M5:
            begin
                if (mrsp.done)
                begin
                    if (p1_reg < mrsp.prod)
                    begin
                        best_next = idx_i;
                        bd_next   = d2_reg;
                        bs2_next  = s2_reg;
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_C_RD;
                end
            end
            S_U_RD:
            begin
                state_next = S_U_WR;
            end
            S_U_WR:
            begin
                // floor of the mean of old box and detection
                wr_en              = 1'b1;
                wr_addr            = best_reg;
                wr_data.ident      = rd.ident;
                wr_data.box.left   = 16'((17'(rd.box.left) + 17'(dbox_reg.left)) >> 1);
                wr_data.box.top    = 16'((17'(rd.box.top) + 17'(dbox_reg.top)) >> 1);
                wr_data.box.width  = 16'((17'(rd.box.width) + 17'(dbox_reg.width)) >> 1);
                wr_data.box.height = 16'((17'(rd.box.height) + 17'(dbox_reg.height)) >> 1);
                wr_data.score      = dscore_reg;
                wr_data.seen       = t_reg;
                wr_data.sight      = (rd.sight == MAX_SIGHTINGS) ? rd.sight
                                                                 : rd.sight + 8'd1;
                used_next[best_reg] = 1'b1;
                state_next          = S_IDLE;
            end
            S_NEW:
            begin
                if (idx_end)
                begin
                    dropped_next = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (!valid_reg[idx_i])
                begin
                    wr_en             = 1'b1;
                    wr_addr           = idx_i;
                    wr_data           = '{next_id_reg, dbox_reg, dscore_reg, t_reg, 8'd1};
                    valid_next[idx_i] = 1'b1;
                    used_next[idx_i]  = 1'b1;
                    next_id_next      = next_id_reg + 32'd1;
                    state_next        = S_IDLE;
                end
                else
                    idx_next = idx_reg + CW'(1);
            end
            S_X_RD:
            begin
                if (idx_end)
                begin
                    idx_next     = '0;
                    found_next   = 1'b0;
                    shown_next   = '0;
                    res_cnt_next = '0;
                    pend_v_next  = 1'b0;
                    state_next   = S_E_RD;
                end
                else
                    state_next = S_X_CHK;
            end
            S_X_CHK:
            begin
                if (valid_reg[idx_i] && (elapsed > keep))
                    valid_next[idx_i] = 1'b0;
                idx_next   = idx_reg + CW'(1);
                state_next = S_X_RD;
            end
            S_E_RD:
            begin
                if (idx_end)
                    state_next = S_E_END;
                else if (valid_reg[idx_i] && !shown_reg[idx_i])
                    state_next = S_E_CHK;
                else
                    idx_next = idx_reg + CW'(1);
            end
            S_E_CHK:
            begin
                if ((rd.sight >= MIN_SIGHTINGS) && (elapsed <= SHOW_MS)
                    && (!found_reg || (rd.ident < pick_id_reg)))
                begin
                    found_next   = 1'b1;
                    best_next    = idx_i;
                    pick_id_next = rd.ident;
                end
                idx_next   = idx_reg + CW'(1);
                state_next = S_E_RD;
            end
            S_E_END:
            begin
                // a held result goes out once it is known whether another follows
                if ((!found_reg || pend_v_reg) && !out_free)
                    state_next = S_E_END;
                else
                begin
                    if (!found_reg || pend_v_reg)
                    begin
                        out_v_next = 1'b1;
                        if (pend_v_reg)
                        begin
                            out_next      = pend_reg;
                            out_next.last = !found_reg;
                        end
                        else
                        begin
                            out_next               = '0;
                            out_next.nothing_shown = 1'b1;
                            out_next.table_full    = dropped_reg;
                            out_next.last          = 1'b1;
                        end
                        pend_v_next = 1'b0;
                    end
                    if (found_reg)
                    begin
                        idx_next   = CW'(best_reg);
                        state_next = S_O_RD;
                    end
                    else
                        state_next = S_FIN;
                end
            end
            S_O_RD:
            begin
                state_next = S_O_LD;
            end
            S_O_LD:
            begin
                pend_next.track_number  = rd.ident;
                pend_next.box           = rd.box;
                pend_next.score         = rd.score;
                pend_next.coasting      = (elapsed > COAST_MS);
                pend_next.nothing_shown = 1'b0;
                pend_next.table_full    = dropped_reg;
                pend_next.last          = 1'b0;
                pend_v_next             = 1'b1;
                shown_next[best_reg]    = 1'b1;
                res_cnt_next            = res_cnt_reg + RES_CW'(1);
                if (res_cnt_reg == RES_CW'(MAX_RESULTS - 1))
                    state_next = S_LASTP;
                else
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_E_RD;
                end
            end
            S_LASTP:
            begin
                if (out_free)
                begin
                    out_v_next    = 1'b1;
                    out_next      = pend_reg;
                    out_next.last = 1'b1;
                    pend_v_next   = 1'b0;
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                used_next    = '0;
                dropped_next = 1'b0;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            best_reg    <= '0;
            found_reg   <= 1'b0;
            valid_reg   <= '0;
            used_reg    <= '0;
            shown_reg   <= '0;
            next_id_reg <= '0;
            dropped_reg <= 1'b0;
            window_reg  <= WINDOW_RESET;
            res_cnt_reg <= '0;
            pend_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            best_reg    <= best_next;
            found_reg   <= found_next;
            valid_reg   <= valid_next;
            used_reg    <= used_next;
            shown_reg   <= shown_next;
            next_id_reg <= next_id_next;
            dropped_reg <= dropped_next;
            window_reg  <= window_next;
            res_cnt_reg <= res_cnt_next;
            pend_v_reg  <= pend_v_next;
            out_v_reg   <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        dbox_reg    <= dbox_next;
        dscore_reg  <= dscore_next;
        darea_reg   <= darea_next;
        inter_reg   <= inter_next;
        union_reg   <= union_next;
        bi_reg      <= bi_next;
        bu_reg      <= bu_next;
        p1_reg      <= p1_next;
        ay_reg      <= ay_next;
        s_reg       <= s_next;
        d2_reg      <= d2_next;
        s2_reg      <= s2_next;
        bd_reg      <= bd_next;
        bs2_reg     <= bs2_next;
        pick_id_reg <= pick_id_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    assign item.ready           = (state_reg == S_IDLE);
    assign cfg.ready            = 1'b1;
    assign result.valid         = out_v_reg;
    assign result.track_number  = out_reg.track_number;
    assign result.out_left      = out_reg.box.left;
    assign result.out_top       = out_reg.box.top;
    assign result.out_width     = out_reg.box.width;
    assign result.out_height    = out_reg.box.height;
    assign result.out_score     = out_reg.score;
    assign result.coasting      = out_reg.coasting;
    assign result.nothing_shown = out_reg.nothing_shown;
    assign result.table_full    = out_reg.table_full;
    assign result.last          = out_reg.last;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item.valid && item.ready |=> !item.ready)
        else $error("input taken again right after a transfer");

    a_used_within_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ((used_reg & ~valid_reg) == '0))
        else $error("used mark on a free slot while idle");

    a_mul_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.start |-> !mrsp.busy)
        else $error("multiplier started while busy");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.ready && result.last |=> !result.valid)
        else $error("result follows the last of a run");
`endif

endmodule

`default_nettype wire
